### design/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg
// Shared widths, operation codes and status codes for the alias table event sampler.
// ----------------------------------------------------------------------------
package ats_pkg;

  localparam int MaxEvents  = 1024;
  localparam int IdxW       = 10;
  localparam int CntW       = 11;
  localparam int WeightW    = 32;
  localparam int UniW       = 32;
  localparam int SumW       = 42;
  localparam int CutW       = 43;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_SUM = 2'd1;
  localparam logic [1:0] ST_NO_TABLE = 2'd2;

endpackage

### design/alias_table_event_sampler.sv
// ----------------------------------------------------------------------------
// alias_table_event_sampler
// Walker alias sampler built around four single-port-read memories.
//
// The input channel carries one operation per transaction: load a weight,
// build the alias table, or draw a sample. Every transaction returns exactly
// one result transaction with the chosen event, the last built total weight
// and a status code.
// A load or a no-op goes straight to the final state, which writes the result
// into the output register once that register is free. A sample runs a column
// multiply, one memory read and a split 32x42 product for the accept test.
// A build for n events sums the weights, sorts the columns by cutoff with an
// exchange sort that reads the order and cutoff memories through one port,
// scans for the first large column and then pairs small and large columns.
// Items are processed one at a time; the block is ready for the next
// transaction as soon as the previous result enters the output register,
// even if that result is still stalled there.
// When the receiver stalls, the result holds and the block waits in its
// final state. Reset clears the table valid flag, the total weight and sets
// the event count to one; the memory contents are undefined until written.
// ----------------------------------------------------------------------------
module alias_table_event_sampler
  import ats_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,   // event_count in bits 10:0
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,      // slot, weight, uniform_column, uniform_accept
  input  logic [1:0]   in_tuser,      // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata,     // event_index, total_weight
  output logic [1:0]   out_tuser      // status
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_SUM0 = 5'd1,  S_SUM1 = 5'd2,  S_SI0 = 5'd3,
                         S_SI1  = 5'd4,  S_SI2  = 5'd5,  S_SM0  = 5'd6,  S_SM1 = 5'd7,
                         S_SM2  = 5'd8,  S_SIW  = 5'd9,  S_SC0  = 5'd10, S_SC1 = 5'd11,
                         S_SC2  = 5'd12, S_P0   = 5'd13, S_P1   = 5'd14, S_P2  = 5'd15,
                         S_P3   = 5'd16, S_P4   = 5'd17, S_X0   = 5'd18, S_X1  = 5'd19,
                         S_X2   = 5'd20, S_FIN  = 5'd21;

  logic [WeightW-1:0] w_mem [MaxEvents];
  logic [CutW-1:0]    c_mem [MaxEvents];
  logic [IdxW-1:0]    a_mem [MaxEvents];
  logic [IdxW-1:0]    o_mem [MaxEvents];

  logic [WeightW-1:0] w_rd_r;
  logic [CutW-1:0]    c_rd_r;
  logic [IdxW-1:0]    a_rd_r;
  logic [IdxW-1:0]    o_rd_r;

  logic [IdxW-1:0] w_ra, c_ra, a_ra, o_ra;
  logic            c_we, a_we, o_we;
  logic [IdxW-1:0] c_wa, a_wa, o_wa;
  logic [CutW-1:0] c_wd;
  logic [IdxW-1:0] a_wd, o_wd;

  logic [4:0]      state_r, state_nxt;
  logic [CntW-1:0] n_r;
  logic            valid_r;
  logic [SumW-1:0] sum_r;
  logic [CntW-1:0] i_r, i_nxt, m_r, m_nxt, hi_r, hi_nxt, lop_r, lop_nxt;
  logic [IdxW-1:0] key_idx_r, key_idx_nxt, cand_r, cand_nxt, big_r, big_nxt;
  logic [IdxW-1:0] small_r, small_nxt;
  logic [CutW-1:0] key_r, key_nxt, cb_r, cb_nxt;
  logic [1:0]      op_r;
  logic [UniW-1:0] uc_r, ua_r;
  logic [IdxW-1:0] col_r, col_nxt;
  logic [63:0]     plo_r, plo_nxt;
  logic [CutW-1:0] phi_r, phi_nxt;
  logic [IdxW-1:0] res_ev_r, res_ev_nxt;
  logic [1:0]      res_st_r, res_st_nxt;
  logic [SumW-1:0] sum_nxt;
  logic            valid_nxt;

  logic            out_valid_r;
  logic [IdxW-1:0] out_ev_r;
  logic [SumW-1:0] out_sum_r;
  logic [1:0]      out_st_r;

  logic            accept;
  logic [CntW-1:0] cfg_n;
  logic [42:0]     col_prod;
  logic [42:0]     nw_prod;
  logic [CutW:0]   nb;
  logic            fin_go;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_sum_r, out_ev_r};
  assign out_tuser  = out_st_r;

  always_comb begin
    if (cfg_wr_data[10:0] == 11'd0) begin
      cfg_n = 11'd1;
    end else if (cfg_wr_data[10:0] > 11'(MaxEvents)) begin
      cfg_n = 11'(MaxEvents);
    end else begin
      cfg_n = cfg_wr_data[10:0];
    end
  end

  assign col_prod = {32'd0, n_r} * {11'd0, uc_r};
  assign nw_prod  = {32'd0, n_r} * {11'd0, w_rd_r};
  assign nb       = {1'b0, cb_r} + {1'b0, c_rd_r} - {2'b00, sum_r};

  always_ff @(posedge clk) begin
    if (accept && in_tuser == OP_LOAD) begin
      w_mem[in_tdata[9:0]] <= in_tdata[41:10];
    end
    w_rd_r <= w_mem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_wa] <= c_wd;
    end
    c_rd_r <= c_mem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_wa] <= a_wd;
    end
    a_rd_r <= a_mem[a_ra];
  end

  always_ff @(posedge clk) begin
    if (o_we) begin
      o_mem[o_wa] <= o_wd;
    end
    o_rd_r <= o_mem[o_ra];
  end

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    m_nxt       = m_r;
    hi_nxt      = hi_r;
    lop_nxt     = lop_r;
    key_idx_nxt = key_idx_r;
    key_nxt     = key_r;
    cand_nxt    = cand_r;
    big_nxt     = big_r;
    small_nxt   = small_r;
    cb_nxt      = cb_r;
    col_nxt     = col_r;
    plo_nxt     = plo_r;
    phi_nxt     = phi_r;
    res_ev_nxt  = res_ev_r;
    res_st_nxt  = res_st_r;
    sum_nxt     = sum_r;
    valid_nxt   = valid_r;
    w_ra = i_r[IdxW-1:0];
    c_ra = col_r;
    a_ra = col_r;
    o_ra = i_r[IdxW-1:0];
    c_we = 1'b0;
    a_we = 1'b0;
    o_we = 1'b0;
    c_wa = i_r[IdxW-1:0];
    a_wa = i_r[IdxW-1:0];
    o_wa = i_r[IdxW-1:0];
    c_wd = nw_prod;
    a_wd = i_r[IdxW-1:0];
    o_wd = i_r[IdxW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_ev_nxt = '0;
          res_st_nxt = ST_OK;
          i_nxt      = '0;
          case (in_tuser)
            OP_BUILD: begin
              sum_nxt   = '0;
              state_nxt = S_SUM0;
            end
            OP_SAMPLE: begin
              if (valid_r) begin
                state_nxt = S_X0;
              end else begin
                res_st_nxt = ST_NO_TABLE;
                state_nxt  = S_FIN;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SUM0: begin
        state_nxt = S_SUM1;
      end
      S_SUM1: begin
        sum_nxt = sum_r + {10'd0, w_rd_r};
        c_we = 1'b1;
        a_we = 1'b1;
        o_we = 1'b1;
        if (i_r + 11'd1 == n_r) begin
          i_nxt     = '0;
          state_nxt = (n_r < 11'd2) ? S_SC0 : S_SI0;
        end else begin
          i_nxt     = i_r + 11'd1;
          state_nxt = S_SUM0;
        end
      end
      S_SI0: begin
        state_nxt = S_SI1;
      end
      S_SI1: begin
        c_ra        = o_rd_r;
        key_idx_nxt = o_rd_r;
        m_nxt       = i_r + 11'd1;
        state_nxt   = S_SI2;
      end
      S_SI2: begin
        key_nxt   = c_rd_r;
        state_nxt = S_SM0;
      end
      S_SM0: begin
        o_ra      = m_r[IdxW-1:0];
        state_nxt = S_SM1;
      end
      S_SM1: begin
        c_ra      = o_rd_r;
        cand_nxt  = o_rd_r;
        state_nxt = S_SM2;
      end
      S_SM2: begin
        if (key_r > c_rd_r) begin
          o_we        = 1'b1;
          o_wa        = m_r[IdxW-1:0];
          o_wd        = key_idx_r;
          key_idx_nxt = cand_r;
          key_nxt     = c_rd_r;
        end
        if (m_r + 11'd1 == n_r) begin
          state_nxt = S_SIW;
        end else begin
          m_nxt     = m_r + 11'd1;
          state_nxt = S_SM0;
        end
      end
      S_SIW: begin
        o_we = 1'b1;
        o_wd = key_idx_r;
        if (({1'b0, i_r} + 12'd2) < {1'b0, n_r}) begin
          i_nxt     = i_r + 11'd1;
          state_nxt = S_SI0;
        end else begin
          i_nxt     = '0;
          state_nxt = S_SC0;
        end
      end
      S_SC0: begin
        if (i_r == n_r) begin
          hi_nxt    = i_r;
          lop_nxt   = i_r;
          state_nxt = S_P0;
        end else begin
          state_nxt = S_SC1;
        end
      end
      S_SC1: begin
        c_ra      = o_rd_r;
        state_nxt = S_SC2;
      end
      S_SC2: begin
        if ({1'b0, c_rd_r} < {2'b00, sum_r}) begin
          i_nxt     = i_r + 11'd1;
          state_nxt = S_SC0;
        end else begin
          hi_nxt    = i_r;
          lop_nxt   = i_r;
          state_nxt = S_P0;
        end
      end
      S_P0: begin
        o_ra = hi_r[IdxW-1:0];
        if (lop_r != 11'd0 && hi_r < n_r) begin
          state_nxt = S_P1;
        end else begin
          valid_nxt  = (sum_r != '0);
          res_st_nxt = (sum_r == '0) ? ST_ZERO_SUM : ST_OK;
          state_nxt  = S_FIN;
        end
      end
      S_P1: begin
        big_nxt   = o_rd_r;
        o_ra      = lop_r[IdxW-1:0] - 10'd1;
        state_nxt = S_P2;
      end
      S_P2: begin
        small_nxt = o_rd_r;
        c_ra      = big_r;
        state_nxt = S_P3;
      end
      S_P3: begin
        cb_nxt    = c_rd_r;
        c_ra      = small_r;
        state_nxt = S_P4;
      end
      S_P4: begin
        a_we = 1'b1;
        a_wa = small_r;
        a_wd = big_r;
        c_we = 1'b1;
        c_wa = big_r;
        c_wd = nb[CutW-1:0];
        if (nb < {2'b00, sum_r}) begin
          o_we   = 1'b1;
          o_wa   = lop_r[IdxW-1:0] - 10'd1;
          o_wd   = big_r;
          hi_nxt = hi_r + 11'd1;
        end else begin
          lop_nxt = lop_r - 11'd1;
        end
        state_nxt = S_P0;
      end
      S_X0: begin
        col_nxt   = col_prod[41:32];
        plo_nxt   = {32'd0, ua_r} * {32'd0, sum_r[31:0]};
        state_nxt = S_X1;
      end
      S_X1: begin
        c_ra      = col_r;
        a_ra      = col_r;
        phi_nxt   = 43'({11'd0, ua_r} * {33'd0, sum_r[41:32]}) + {11'd0, plo_r[63:32]};
        state_nxt = S_X2;
      end
      S_X2: begin
        res_ev_nxt = (phi_r < c_rd_r) ? col_r : a_rd_r;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_wr_en) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= 11'd1;
      valid_r     <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      sum_r   <= sum_nxt;
      if (cfg_wr_en) begin
        n_r <= cfg_n;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    m_r       <= m_nxt;
    hi_r      <= hi_nxt;
    lop_r     <= lop_nxt;
    key_idx_r <= key_idx_nxt;
    key_r     <= key_nxt;
    cand_r    <= cand_nxt;
    big_r     <= big_nxt;
    small_r   <= small_nxt;
    cb_r      <= cb_nxt;
    col_r     <= col_nxt;
    plo_r     <= plo_nxt;
    phi_r     <= phi_nxt;
    res_ev_r  <= res_ev_nxt;
    res_st_r  <= res_st_nxt;
    if (accept) begin
      op_r     <= in_tuser;
      uc_r     <= in_tdata[73:42];
      ua_r     <= in_tdata[105:74];
    end
    if (fin_go) begin
      out_ev_r  <= (op_r == OP_SAMPLE) ? res_ev_r : '0;
      out_sum_r <= sum_r;
      out_st_r  <= (op_r == OP_NOP || op_r == OP_LOAD) ? ST_OK : res_st_r;
    end
  end

endmodule

### sim/alias_table_event_sampler_checker.sv
// ----------------------------------------------------------------------------
// alias_table_event_sampler_checker
// Watches the configuration port and both stream channels of the sampler.
// Every accepted input transaction runs through a local alias table model.
// The expected result is queued, and each output transaction is compared
// with the oldest entry, field by field.
// ----------------------------------------------------------------------------
module alias_table_event_sampler_checker
  import ats_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [55:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [IdxW-1:0] event_index;
    logic [SumW-1:0] total_weight;
    logic [1:0]      status;
  } draw_result_t;

  logic [63:0] weights    [MaxEvents];
  logic [63:0] cutoffs    [MaxEvents];
  logic [31:0] aliases    [MaxEvents];
  logic [31:0] order      [MaxEvents];
  logic [63:0] total_sum;
  logic        table_ok;
  int          n_events;
  draw_result_t results_due[$];

  function automatic void model_table_build();
    logic [63:0] s;
    int          i, m, lo, hi;
    logic [31:0] t, big, little;
    s = 0;
    for (i = 0; i < n_events; i++) s += weights[i];
    total_sum = s;
    for (i = 0; i < n_events; i++) begin
      cutoffs[i] = 64'(n_events) * weights[i];
      aliases[i] = i;
      order[i]   = i;
    end
    for (i = 0; i + 1 < n_events; i++)
      for (m = i + 1; m < n_events; m++)
        if (cutoffs[order[i]] > cutoffs[order[m]]) begin
          t        = order[i];
          order[i] = order[m];
          order[m] = t;
        end
    i = 0;
    while (i < n_events && cutoffs[order[i]] < s) i++;
    hi = i;
    lo = hi - 1;
    while (lo > -1 && hi < n_events) begin
      big             = order[hi];
      little          = order[lo];
      aliases[little] = big;
      cutoffs[big]    = cutoffs[big] + cutoffs[little] - s;
      if (cutoffs[big] < s) begin
        order[lo] = order[hi];
        hi++;
      end else begin
        lo--;
      end
    end
    table_ok = (s != 0);
  endfunction

  function automatic draw_result_t predict_draw(logic [1:0] op, logic [111:0] d);
    draw_result_t r;
    logic [63:0]  u1, u2, col, plo, phi;
    r = '0;
    case (op)
      OP_LOAD: weights[d[9:0]] = {32'd0, d[41:10]};
      OP_BUILD: begin
        model_table_build();
        if (total_sum == 0) r.status = ST_ZERO_SUM;
      end
      OP_SAMPLE: begin
        if (!table_ok) begin
          r.status = ST_NO_TABLE;
        end else begin
          u1  = {32'd0, d[73:42]};
          u2  = {32'd0, d[105:74]};
          col = (64'(n_events) * u1) >> 32;
          if (col >= 64'(n_events)) col = 64'(n_events) - 1;
          plo = u2 * {32'd0, total_sum[31:0]};
          phi = u2 * (total_sum >> 32) + (plo >> 32);
          r.event_index = (phi < cutoffs[col]) ? col[IdxW-1:0] : aliases[col][IdxW-1:0];
        end
      end
      default: ;
    endcase
    r.total_weight = total_sum[SumW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    draw_result_t want, got;
    int           v;
    if (!rst_n) begin
      total_sum = 0;
      table_ok  = 0;
      n_events  = 1;
      results_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        v = int'(cfg_wr_data[CntW-1:0]);
        if (v < 1) v = 1;
        if (v > MaxEvents) v = MaxEvents;
        n_events = v;
        table_ok = 0;
      end
      if (out_tvalid && out_tready) begin
        got.event_index  = out_tdata[9:0];
        got.total_weight = out_tdata[51:10];
        got.status       = out_tuser;
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: index %0d total %0d status %0d",
                     got.event_index, got.total_weight, got.status);
        end else begin
          want = results_due.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: index %0d/%0d total %0d/%0d status %0d/%0d (exp/act)",
                       want.event_index, got.event_index, want.total_weight,
                       got.total_weight, want.status, got.status);
          end
        end
      end
      if (in_tvalid && in_tready) results_due.push_back(predict_draw(in_tuser, in_tdata));
    end
    pending = results_due.size();
  end

endmodule

### sim/alias_table_event_sampler_test.sv
// ----------------------------------------------------------------------------
// alias_table_event_sampler_test
// Drives loads, builds, samples and no-ops into the sampler over several
// event counts, including the clamped extremes, with random gaps and
// back-pressure. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module alias_table_event_sampler_test;
  import ats_pkg::*;

  localparam int StallLimit = 400000;

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic [15:0]  cfg_wr_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;
  logic [1:0]   out_tuser;
  int           fail_count;
  int           pending;
  int           quiet_cycles;
  bit           steady;
  int           n_active;

  alias_table_event_sampler dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  alias_table_event_sampler_checker checker_i (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    if (steady) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (steady) out_tready <= 1'b1;
    else if ($urandom_range(0, 49) == 0) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("alias_table_event_sampler verification failed");
      $finish;
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [9:0] slot,
                         input logic [31:0] w, input logic [31:0] uc,
                         input logic [31:0] ua);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, ua, uc, w, slot};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_count(input logic [15:0] raw);
    int v;
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= raw;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    v = int'(raw[10:0]);
    n_active = (v < 1) ? 1 : (v > MaxEvents) ? MaxEvents : v;
  endtask

  task automatic random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      send_op(OP_SAMPLE, 10'($urandom), $urandom, pick_value(), pick_value());
    else if (r < 88)
      send_op(OP_LOAD, 10'($urandom_range(0, n_active - 1)), pick_value(), $urandom,
              $urandom);
    else if (r < 93)
      send_op(OP_LOAD, 10'($urandom), pick_value(), $urandom, $urandom);
    else if (r < 97)
      send_op(OP_BUILD, 10'($urandom), $urandom, $urandom, $urandom);
    else
      send_op(OP_NOP, 10'($urandom), $urandom, $urandom, $urandom);
  endtask

  initial begin
    int ph, k, items;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_NOP;
    steady       = 1'b0;
    n_active     = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: no table yet, zero sum, extreme weights and uniforms.
    send_op(OP_SAMPLE, 10'd0, 32'd0, 32'd0, 32'd0);
    send_op(OP_NOP, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_LOAD, 10'd0, 32'd0, 32'd0, 32'd0);
    send_op(OP_BUILD, 10'd0, 32'd0, 32'd0, 32'd0);
    send_op(OP_SAMPLE, 10'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_op(OP_LOAD, 10'h3FF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_op(OP_LOAD, 10'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_op(OP_BUILD, 10'd0, 32'd0, 32'd0, 32'd0);
    send_op(OP_SAMPLE, 10'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_count(16'd0);
    send_op(OP_SAMPLE, 10'd0, 32'd0, 32'd0, 32'd0);
    set_count(16'd4);
    send_op(OP_LOAD, 10'd1, 32'd1, 32'd0, 32'd0);
    send_op(OP_LOAD, 10'd2, 32'd0, 32'd0, 32'd0);
    send_op(OP_LOAD, 10'd3, 32'd7, 32'd0, 32'd0);
    send_op(OP_BUILD, 10'd0, 32'd0, 32'd0, 32'd0);
    send_op(OP_SAMPLE, 10'd0, 32'd0, 32'd0, 32'd0);
    send_op(OP_SAMPLE, 10'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_SAMPLE, 10'd0, 32'd0, 32'h4000_0000, 32'h8000_0000);
    set_count(16'hFFFF);
    send_op(OP_LOAD, 10'h3FF, 32'h1234_5678, 32'd0, 32'd0);
    send_op(OP_SAMPLE, 10'd0, 32'd0, 32'h8000_0000, 32'h8000_0000);
    set_count(16'd1024);
    send_op(OP_SAMPLE, 10'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);

    // Random phases, each with a fresh count and a full preload of its slots.
    for (ph = 0; ph < 10; ph++) begin
      steady = (ph % 4 == 3);
      if (ph == 6) set_count(16'd160);
      else if (ph == 2) set_count(16'd2);
      else set_count(16'($urandom & 32'hF800) | 16'($urandom_range(1, 24)));
      for (k = 0; k < n_active; k++)
        send_op(OP_LOAD, 10'(k), (ph == 4) ? 32'd0 : pick_value(), $urandom, $urandom);
      send_op(OP_BUILD, 10'($urandom), $urandom, $urandom, $urandom);
      items = (ph == 6) ? 80 : 190;
      for (k = 0; k < items; k++) random_op();
    end
    steady = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("alias_table_event_sampler verification clean");
    end else begin
      $display("alias_table_event_sampler verification failed");
    end
    $finish;
  end

endmodule

### alias_table_event_sampler.f
design/ats_pkg.sv
design/alias_table_event_sampler.sv
sim/alias_table_event_sampler_checker.sv
sim/alias_table_event_sampler_test.sv
